// ----- rtl/pose_integrator_go_to_goal_assert.svh -----
// Assertion macros for the pose integrator checker.
`ifndef POSE_INTEGRATOR_GO_TO_GOAL_ASSERT_SVH
`define POSE_INTEGRATOR_GO_TO_GOAL_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PIGG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define PIGG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define PIGG_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pigg_pkg.sv -----
`default_nettype none
package pigg_pkg;

  localparam int POS_W   = 32;
  localparam int ANG_W   = 16;
  localparam int REG_W   = 31;
  localparam int CW      = 45;  // CORDIC x/y, covers 2^41 start plus gain
  localparam int ZW      = 34;
  localparam int MW      = 33;  // multiplier operand width
  localparam int PW      = 2 * MW;
  localparam int OFF_W   = 33;
  localparam int SQ_W    = 64;
  localparam int ROOT_W  = 33;
  localparam int DISP_W  = 35;
  localparam int NORM_BIT  = 40;
  localparam int COARSE_BIT = 32;
  localparam int COARSE_SHIFT = 8;
  localparam longint INV_GAIN_Q30 = 64'd652032874;

  localparam logic [REG_W-1:0] MAX_STEP_RST = 31'd65536;
  localparam logic [REG_W-1:0] GOAL_TOL_RST = 31'd6554;

  localparam logic CFG_MAX_STEP = 1'b0;
  localparam logic CFG_GOAL_TOL = 1'b1;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_GOAL = 1'b1;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctrl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pigg_ifs.sv -----
`default_nettype none
interface pigg_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic signed [15:0] turn;
  logic signed [31:0] advance;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;

  modport source (output valid, cmd, turn, advance, goal_x, goal_y, input ready);
  modport sink   (input valid, cmd, turn, advance, goal_x, goal_y, output ready);
endinterface

interface pigg_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic        goal_reached;
  logic        saturated;

  modport source (output valid, pos_x, pos_y, heading, goal_reached, saturated,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading, goal_reached, saturated,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/pigg_cordic.sv -----
`default_nettype none
// Shared iterative CORDIC: one micro-rotation per cycle, rotation or vectoring.
module pigg_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pigg_pkg::cordic_ctrl_t            ctrl,
  input  logic signed [pigg_pkg::CW-1:0]    x0,
  input  logic signed [pigg_pkg::CW-1:0]    y0,
  input  logic signed [pigg_pkg::ZW-1:0]    z0,
  output logic signed [pigg_pkg::CW-1:0]    x,
  output logic signed [pigg_pkg::CW-1:0]    y,
  output logic signed [pigg_pkg::ZW-1:0]    z,
  output logic                              done
);

  localparam int IDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(STAGES - 1);

  logic             busy;
  logic             mode;
  logic [IDX_W-1:0] cnt;
  logic signed [pigg_pkg::CW-1:0] xs, ys;
  logic signed [pigg_pkg::ZW-1:0] at;
  logic             ccw;

  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    at  = pigg_pkg::ZW'(pigg_pkg::atan_entry(5'(cnt)));
    // vectoring drives y to zero, rotation drives z to zero
    ccw = mode ? y[pigg_pkg::CW-1] : ~z[pigg_pkg::ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      x    <= x0;
      y    <= y0;
      z    <= z0;
      mode <= ctrl.vectoring;
    end else if (busy) begin
      if (ccw) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pigg_isqrt.sv -----
`default_nettype none
// Bit-pair square root, one result bit per cycle, rounded to nearest.
module pigg_isqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pigg_pkg::SQ_W-1:0]        value,
  output logic [pigg_pkg::ROOT_W-1:0]      root,
  output logic                             done
);

  logic                        busy;
  logic [pigg_pkg::SQ_W-1:0]   r, rem, bitm, trial;

  assign trial = r + bitm;
  // remainder is v - r*r, so round up when it exceeds r
  assign root  = (rem > r) ? pigg_pkg::ROOT_W'(r + 1'b1) : pigg_pkg::ROOT_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r    <= '0;
      rem  <= value;
      bitm <= pigg_pkg::SQ_W'(1) << (pigg_pkg::SQ_W - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        r   <= (r >> 1) + bitm;
      end else begin
        r   <= r >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pose_integrator_go_to_goal.sv -----
// Move transaction: heading update, rotation pass, two multiplies, pose update.
// Goal transaction: squares of both offsets, up to 12 normalise shifts, vectoring
// pass, 32-step square root, rotation pass and two displacement multiplies.
// One transaction at a time: the next can be taken in the same cycle as the result
// is first presented; a stalled result holds the block in its last state.
// Synchronous reset: pose zero, max_step 1.0, goal_tolerance 0.1, no result.
`default_nettype none
module pose_integrator_go_to_goal #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  pigg_req_if.sink                      req,
  pigg_rsp_if.source                    rsp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pigg_pkg::REG_W-1:0]    cfg_data
);

  localparam int CW = pigg_pkg::CW;
  localparam int ZW = pigg_pkg::ZW;
  localparam int MW = pigg_pkg::MW;
  localparam int PW = pigg_pkg::PW;
  localparam int OW = pigg_pkg::OFF_W;
  localparam int DW = pigg_pkg::DISP_W;
  localparam longint X_INIT_L =
    (pigg_pkg::INV_GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [CW-1:0] X_INIT = CW'(X_INIT_L);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CW-1:0] NORM_LIM = CW'(1) <<< pigg_pkg::NORM_BIT;
  localparam logic signed [CW-1:0] COARSE_LIM = CW'(1) <<< pigg_pkg::COARSE_BIT;
  localparam logic [OW-1:0] BIG_LIM = OW'(1) << 31;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(34'h0_8000_0000);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_VEC  = 4'd5;
  localparam logic [3:0] S_QGO  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_RGO  = 4'd8;
  localparam logic [3:0] S_ROT  = 4'd9;
  localparam logic [3:0] S_MULC = 4'd10;
  localparam logic [3:0] S_ADDX = 4'd11;
  localparam logic [3:0] S_ADDY = 4'd12;
  localparam logic [3:0] S_UPDY = 4'd13;
  localparam logic [3:0] S_CHK  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state;

  logic [pigg_pkg::REG_W-1:0] max_step, goal_tol;
  logic signed [31:0] pose_x, pose_y;
  logic [15:0]        heading;

  logic               cmd;
  logic signed [31:0] goal_x, goal_y;
  logic signed [OW-1:0] dx, dy;
  logic signed [MW-1:0] step_len;
  logic               big, zero, fold, flip, sat, reached;
  logic signed [CW-1:0] vx, vy;
  logic [pigg_pkg::SQ_W-1:0] sq_acc;
  logic signed [PW-1:0] mul_p;
  logic signed [DW-1:0] disp;

  logic signed [MW-1:0] mul_a, mul_b, cos_v, sin_v;
  logic [OW-1:0]        adx, ady, rdx, rdy;
  logic signed [CW-1:0] avy;
  logic                 norm_done;
  logic                 rflip;
  logic signed [PW-1:0] rnd;
  logic signed [DW-1:0] disp_new;
  logic signed [DW+1:0] sum;
  logic signed [31:0]   sum_clip;
  logic                 sum_sat;
  logic signed [OW-1:0] ndx, ndy;
  logic [31:0]          zr;

  pigg_pkg::cordic_ctrl_t cctl;
  logic signed [CW-1:0] c_x0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;
  logic                 c_done;

  logic                 q_start, q_done;
  logic [pigg_pkg::ROOT_W-1:0] q_root;

  assign req.ready = (state == S_IDLE);

  // offsets and their magnitudes
  always_comb begin
    adx = dx[OW-1] ? OW'(-dx) : OW'(dx);
    ady = dy[OW-1] ? OW'(-dy) : OW'(dy);
    avy = vy[CW-1] ? -vy : vy;
    norm_done = !((vx < NORM_LIM) && (avy < NORM_LIM));
    ndx = OW'(goal_x) - OW'(pose_x);
    ndy = OW'(goal_y) - OW'(pose_y);
    rdx = ndx[OW-1] ? OW'(-ndx) : OW'(ndx);
    rdy = ndy[OW-1] ? OW'(-ndy) : OW'(ndy);
    zr  = c_z[31:0] + 32'h0000_8000;
  end

  // shared CORDIC control
  always_comb begin
    // second and third quadrants fold by a half turn
    rflip          = heading[15] ^ heading[14];
    cctl.start     = (state == S_NORM && norm_done) || (state == S_RGO);
    cctl.vectoring = (state == S_NORM);
    c_x0 = (state == S_NORM) ? vx : X_INIT;
    c_z0 = (state == S_NORM) ? (fold ? HALF_TURN : '0)
                             : ZW'($signed({heading[15] ^ rflip, heading[14:0], 16'h0000}));
    cos_v = flip ? MW'(-c_x) : MW'(c_x);
    sin_v = flip ? MW'(-c_y) : MW'(c_y);
  end

  pigg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .ctrl (cctl),
    .x0   (c_x0),
    .y0   ((state == S_NORM) ? vy : '0),
    .z0   (c_z0),
    .x    (c_x),
    .y    (c_y),
    .z    (c_z),
    .done (c_done)
  );

  assign q_start = (state == S_QGO) && !big && !zero;

  pigg_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (q_start),
    .value (sq_acc),
    .root  (q_root),
    .done  (q_done)
  );

  // one multiplier, registered output
  always_comb begin
    case (state)
      S_SQY:  begin mul_a = MW'(dy);  mul_b = MW'(dy); end
      S_MULC: begin mul_a = step_len; mul_b = cos_v;   end
      S_ADDX: begin mul_a = step_len; mul_b = sin_v;   end
      default: begin mul_a = MW'(dx); mul_b = MW'(dx); end
    endcase
    rnd      = mul_p + HALF;
    disp_new = DW'(rnd >>> FRAC_BITS);
    sum      = (state == S_ADDY) ? ((DW+2)'(pose_x) + (DW+2)'(disp))
                                 : ((DW+2)'(pose_y) + (DW+2)'(disp));
    sum_sat  = 1'b1;
    if (sum > (DW+2)'(32'sh7FFF_FFFF)) begin
      sum_clip = 32'sh7FFF_FFFF;
    end else if (sum < -((DW+2)'(33'sh0_8000_0000))) begin
      sum_clip = 32'sh8000_0000;
    end else begin
      sum_clip = 32'(sum);
      sum_sat  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= pigg_pkg::MAX_STEP_RST;
      goal_tol <= pigg_pkg::GOAL_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pigg_pkg::CFG_MAX_STEP: max_step <= cfg_data;
        pigg_pkg::CFG_GOAL_TOL: goal_tol <= cfg_data;
      endcase
    end
  end

  // sequencer and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pose_x  <= '0;
      pose_y  <= '0;
      heading <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.cmd == pigg_pkg::CMD_MOVE) begin
              heading <= heading + req.turn;
              state   <= S_RGO;
            end else begin
              state   <= S_SQX;
            end
          end
        end
        S_SQX:  state <= S_SQY;
        S_SQY:  state <= S_SUM;
        S_SUM: begin
          if (zero) begin
            heading <= '0;
            state   <= S_QGO;
          end else begin
            state   <= S_NORM;
          end
        end
        S_NORM: if (norm_done) state <= S_VEC;
        S_VEC: begin
          if (c_done) begin
            heading <= zr[31:16];
            state   <= S_QGO;
          end
        end
        S_QGO:  state <= q_start ? S_SQRT : S_RGO;
        S_SQRT: if (q_done) state <= S_RGO;
        S_RGO:  state <= S_ROT;
        S_ROT:  if (c_done) state <= S_MULC;
        S_MULC: state <= S_ADDX;
        S_ADDX: state <= S_ADDY;
        S_ADDY: begin
          pose_x <= sum_clip;
          state  <= S_UPDY;
        end
        S_UPDY: begin
          pose_y <= sum_clip;
          state  <= (cmd == pigg_pkg::CMD_GOAL) ? S_CHK : S_DONE;
        end
        S_CHK:  state <= S_DONE;
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd      <= req.cmd;
        goal_x   <= req.goal_x;
        goal_y   <= req.goal_y;
        dx       <= OW'(req.goal_x) - OW'(pose_x);
        dy       <= OW'(req.goal_y) - OW'(pose_y);
        step_len <= MW'(req.advance);
        sat      <= 1'b0;
        reached  <= 1'b0;
      end
      S_SQX: begin
        big  <= (adx >= BIG_LIM) || (ady >= BIG_LIM);
        zero <= (dx == '0) && (dy == '0);
        fold <= dx[OW-1];
        vx   <= dx[OW-1] ? -CW'(dx) : CW'(dx);
        vy   <= dx[OW-1] ? -CW'(dy) : CW'(dy);
      end
      S_SQY:  sq_acc <= pigg_pkg::SQ_W'(mul_p);
      S_SUM:  sq_acc <= sq_acc + pigg_pkg::SQ_W'(mul_p);
      S_NORM: begin
        if (!norm_done) begin
          if (vx < COARSE_LIM && avy < COARSE_LIM) begin
            vx <= vx <<< pigg_pkg::COARSE_SHIFT;
            vy <= vy <<< pigg_pkg::COARSE_SHIFT;
          end else begin
            vx <= vx <<< 1;
            vy <= vy <<< 1;
          end
        end
      end
      S_QGO: begin
        if (zero) begin
          step_len <= '0;
        end else if (big) begin
          step_len <= MW'(max_step);
        end
      end
      S_SQRT: begin
        if (q_done) begin
          step_len <= (q_root < MW'(max_step)) ? MW'(q_root) : MW'(max_step);
        end
      end
      S_RGO:  flip <= rflip;
      S_ADDX: disp <= disp_new;
      S_ADDY: begin
        disp <= disp_new;
        sat  <= sat | sum_sat;
      end
      S_UPDY: sat <= sat | sum_sat;
      S_CHK:  reached <= (rdx < OW'(goal_tol)) && (rdy < OW'(goal_tol));
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.pos_x        <= pose_x;
      rsp.pos_y        <= pose_y;
      rsp.heading      <= heading;
      rsp.goal_reached <= reached;
      rsp.saturated    <= sat;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pigg_checker.sv -----
`default_nettype none
`include "pose_integrator_go_to_goal_assert.svh"
module pigg_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic signed [31:0] rsp_pos_x,
  input logic signed [31:0] rsp_pos_y,
  input logic signed [15:0] rsp_heading,
  input logic               rsp_goal_reached,
  input logic               rsp_saturated
);

  // result held while stalled
  `PIGG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `PIGG_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_heading) && $stable(rsp_goal_reached) && $stable(rsp_saturated), "result changed while stalled")
  // an accepted transaction keeps the block busy
  `PIGG_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "ready right after accept")
  `PIGG_ASSERT_NEXT_ALWAYS(a_rst, rst, !rsp_valid, "result valid after reset")
  // a valid result never carries an unknown reached flag
  `PIGG_ASSERT_NOW(a_known, rsp_valid, !$isunknown(rsp_goal_reached), "unknown reached flag")

endmodule

bind pose_integrator_go_to_goal pigg_checker u_pigg_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_pos_x        (rsp.pos_x),
  .rsp_pos_y        (rsp.pos_y),
  .rsp_heading      (rsp.heading),
  .rsp_goal_reached (rsp.goal_reached),
  .rsp_saturated    (rsp.saturated)
);
`default_nettype wire

// ----- bench/tb_pose_integrator_go_to_goal.sv -----
`default_nettype none
module tb_pose_integrator_go_to_goal;

  localparam int STAGES     = 16;
  localparam int FRAC       = 16;
  localparam int DRAIN_CYC  = 120;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic               cmd;
    logic signed [15:0] turn;
    logic signed [31:0] advance;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
  } step_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic               goal_reached;
    logic               saturated;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [pigg_pkg::REG_W-1:0] cfg_data = '0;

  pigg_req_if req_ch();
  pigg_rsp_if rsp_ch();

  pose_integrator_go_to_goal dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // arctangent table, 2^32 per turn
  logic [31:0] atan_lut [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // predicted pose and register copies
  logic [pigg_pkg::REG_W-1:0] step_limit = pigg_pkg::MAX_STEP_RST;
  logic [pigg_pkg::REG_W-1:0] tol_limit  = pigg_pkg::GOAL_TOL_RST;
  logic signed [31:0] cur_x = '0;
  logic signed [31:0] cur_y = '0;
  logic [15:0]        cur_hdg = '0;

  pose_t pose_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    calm = 1'b0;

  function automatic void cos_sin(input logic [15:0] ang, output longint c, output longint s);
    logic [31:0] a;
    longint x, y, z, xs, ys;
    bit flip;
    a = {ang, 16'h0000};
    flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    if (flip) a = a + 32'h80000000;
    z = longint'($signed(a));
    x = (pigg_pkg::INV_GAIN_Q30 + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - longint'(atan_lut[i]);
      end else begin
        x = x + ys; y = y - xs; z = z + longint'(atan_lut[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [15:0] bearing(input longint dx_in, input longint dy_in);
    logic [31:0] z, t;
    longint dx, dy, ax, ay, xs, ys;
    dx = dx_in; dy = dy_in; z = '0;
    if (dx == 0 && dy == 0) return 16'h0000;
    if (dx < 0) begin
      dx = -dx; dy = -dy; z = 32'h80000000;
    end
    ax = dx;
    ay = (dy < 0) ? -dy : dy;
    while (((ax > ay) ? ax : ay) < (64'sd1 <<< 40)) begin
      dx = dx * 2; dy = dy * 2; ax = ax * 2; ay = ay * 2;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = dx >>> i;
      ys = dy >>> i;
      if (dy >= 0) begin
        dx = dx + ys; dy = dy - xs; z = z + atan_lut[i];
      end else begin
        dx = dx - ys; dy = dy + xs; z = z - atan_lut[i];
      end
    end
    t = z + 32'h00008000;
    return t[31:16];
  endfunction

  function automatic longint root_nearest(input logic [63:0] v);
    logic [63:0] r, b, rem;
    r = '0; b = 64'd1 << 62; rem = v;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v - r * r > r) r = r + 1;
    return longint'(r);
  endfunction

  function automatic logic signed [31:0] clip(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1; return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1; return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic void travel(input longint step_len, inout logic sat);
    longint c, s, half;
    half = 64'sd1 <<< (FRAC - 1);
    cos_sin(cur_hdg, c, s);
    cur_x = clip(longint'(cur_x) + ((step_len * c + half) >>> FRAC), sat);
    cur_y = clip(longint'(cur_y) + ((step_len * s + half) >>> FRAC), sat);
  endfunction

  function automatic pose_t predict_pose(input step_t it);
    pose_t r;
    longint gx, gy, dx, dy, ax, ay, step_len, d;
    logic sat, hit;
    sat = 1'b0; hit = 1'b0;
    if (it.cmd == pigg_pkg::CMD_MOVE) begin
      cur_hdg = cur_hdg + it.turn;
      travel(longint'(it.advance), sat);
    end else begin
      gx = longint'(it.goal_x); gy = longint'(it.goal_y);
      dx = gx - cur_x; dy = gy - cur_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      step_len = longint'(step_limit);
      cur_hdg = bearing(dx, dy);
      if (ax < 64'sd2147483648 && ay < 64'sd2147483648) begin
        d = root_nearest(64'(dx * dx) + 64'(dy * dy));
        if (d < step_len) step_len = d;
      end
      travel(step_len, sat);
      dx = gx - cur_x; dy = gy - cur_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      hit = (ax < longint'(tol_limit)) && (ay < longint'(tol_limit));
    end
    r.pos_x = cur_x; r.pos_y = cur_y; r.heading = cur_hdg;
    r.goal_reached = hit; r.saturated = sat;
    return r;
  endfunction

  // response side: random back-pressure and checking
  always @(negedge clk) begin
    rsp_ch.ready <= (!calm && $urandom_range(99) < 17) ? 1'b0 : 1'b1;
  end

  always @(posedge clk) begin
    pose_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (rsp_ch.pos_x !== e.pos_x) begin
          $error("pos_x: expected %0d, got %0d", e.pos_x, rsp_ch.pos_x);
          errors++;
        end
        if (rsp_ch.pos_y !== e.pos_y) begin
          $error("pos_y: expected %0d, got %0d", e.pos_y, rsp_ch.pos_y);
          errors++;
        end
        if (rsp_ch.heading !== e.heading) begin
          $error("heading: expected %0d, got %0d", e.heading, rsp_ch.heading);
          errors++;
        end
        if (rsp_ch.goal_reached !== e.goal_reached) begin
          $error("goal_reached: expected %0b, got %0b", e.goal_reached,
                 rsp_ch.goal_reached);
          errors++;
        end
        if (rsp_ch.saturated !== e.saturated) begin
          $error("saturated: expected %0b, got %0b", e.saturated, rsp_ch.saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_step(input step_t it);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= it.cmd;
    req_ch.turn    <= it.turn;
    req_ch.advance <= it.advance;
    req_ch.goal_x  <= it.goal_x;
    req_ch.goal_y  <= it.goal_y;
    do @(posedge clk); while (!req_ch.ready);
    pose_q.insert(pose_q.size(), predict_pose(it));
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [pigg_pkg::REG_W-1:0] val);
    go_quiet();
    drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pigg_pkg::CFG_MAX_STEP) step_limit = val;
    else tol_limit = val;
  endtask

  function automatic step_t mv(input logic signed [15:0] t, input logic signed [31:0] a);
    step_t s;
    s.cmd = pigg_pkg::CMD_MOVE; s.turn = t; s.advance = a;
    s.goal_x = $urandom; s.goal_y = $urandom;
    return s;
  endfunction

  function automatic step_t gl(input logic signed [31:0] x, input logic signed [31:0] y);
    step_t s;
    s.cmd = pigg_pkg::CMD_GOAL; s.goal_x = x; s.goal_y = y;
    s.turn = 16'($urandom); s.advance = $urandom;
    return s;
  endfunction

  function automatic logic signed [31:0] near(input logic signed [31:0] p, input int span);
    longint v;
    v = longint'(p) + $signed($urandom_range(2 * span, 0)) - span;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic test_directed();
    send_step(gl(cur_x, cur_y));                 // zero offset
    send_step(mv(16'sh7FFF, 32'sd65536));
    send_step(mv(-16'sh8000, 32'sd65536));
    send_step(mv(16'sd0, -32'sd196608));
    send_step(mv(16'sd16384, 32'sd0));
    send_step(mv(-16'sd16384, 32'sd1000000));
    send_step(gl(32'sd65536, 32'sd0));
    send_step(gl(-32'sd65536, -32'sd65536));
    send_step(gl(cur_x, cur_y));
    send_step(mv(16'sd0, 32'sh7FFFFFFF));        // clips x high
    send_step(mv(16'sd0, 32'sh7FFFFFFF));
    send_step(mv(-16'sh8000, 32'sh7FFFFFFF));    // heading half turn
    send_step(mv(16'sd0, 32'sh80000000));
    send_step(gl(32'sh80000000, 32'sh80000000)); // offset beyond 2^31
    send_step(gl(32'sh7FFFFFFF, 32'sh80000000));
    send_step(gl(32'sh7FFFFFFF, 32'sh7FFFFFFF));
    send_step(mv(16'sd8192, 32'sh80000000));
    send_step(gl(32'sd0, 32'sd0));
    send_step(gl(32'sd0, 32'sd0));
    send_step(mv(16'shFFFF, 32'shFFFFFFFF));
    send_step(gl(near(cur_x, 3000), near(cur_y, 3000)));
  endtask

  task automatic test_random(input int count);
    step_t s;
    logic signed [31:0] gx, gy;
    int n, k;
    n = 0;
    while (n < count) begin
      k = $urandom_range(99);
      if (k < 45) begin
        // goal run: repeat one goal one to eight times
        gx = ($urandom_range(9) == 0) ? $signed($urandom) : near(cur_x, 400000);
        gy = ($urandom_range(9) == 0) ? $signed($urandom) : near(cur_y, 400000);
        repeat ($urandom_range(1, 8)) begin
          send_step(gl(gx, gy));
          n++;
        end
      end else if (k < 80) begin
        s = mv(16'($urandom), $signed($urandom_range(400000, 0)) - 200000);
        send_step(s);
        n++;
      end else if (k < 90) begin
        send_step(mv(16'($urandom), $urandom));
        n++;
      end else begin
        send_step(gl($urandom, $urandom));
        n++;
      end
    end
  endtask

  task automatic test_settings();
    write_reg(pigg_pkg::CFG_MAX_STEP, 31'd0);
    write_reg(pigg_pkg::CFG_GOAL_TOL, 31'h7FFFFFFF);
    test_random(150);
    write_reg(pigg_pkg::CFG_MAX_STEP, 31'h7FFFFFFF);
    write_reg(pigg_pkg::CFG_GOAL_TOL, 31'd0);
    test_random(250);
    write_reg(pigg_pkg::CFG_MAX_STEP, 31'd200000);
    write_reg(pigg_pkg::CFG_GOAL_TOL, 31'd20000);
    calm = 1'b1;
    test_random(250);
    calm = 1'b0;
    write_reg(pigg_pkg::CFG_MAX_STEP, 31'($urandom));
    write_reg(pigg_pkg::CFG_GOAL_TOL, 31'($urandom_range(100000, 1)));
    test_random(350);
  endtask

  initial begin
    req_ch.valid = 1'b0; req_ch.cmd = pigg_pkg::CMD_MOVE; req_ch.turn = '0;
    req_ch.advance = '0; req_ch.goal_x = '0; req_ch.goal_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(400);
    test_settings();
    go_quiet();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
